// ===== hdl/ffsa_pkg.sv =====
// Package for the first-fit segment allocator: payload types, wave and commit types, constants.
package ffsa_pkg;

    localparam int MAX_SEGMENTS_DEF = 64;
    localparam int LEN_W            = 16;
    localparam int OWNER_W          = 16;
    localparam int UNITS_W          = 15;
    localparam int POS_W            = 7;
    localparam logic [LEN_W-1:0] RESET_SIZE = 16'd256;

    typedef struct packed {
        logic [OWNER_W-1:0] owner_id;
        logic [UNITS_W-1:0] request_units;
    } req_t;

    typedef struct packed {
        logic               granted;
        logic [POS_W-1:0]   segment_position;
        logic [LEN_W-1:0]   start_address;
        logic [LEN_W-1:0]   free_remaining;
    } resp_t;

    // Search wave that travels down the cell row, one cell per cycle.
    typedef struct packed {
        logic             act;
        logic             found;
        logic [LEN_W-1:0] addr;
        logic [LEN_W-1:0] len;
    } wave_t;

    // Update broadcast to all cells after a successful search.
    typedef struct packed {
        logic               en;
        logic               split;
        logic [LEN_W-1:0]   need;
        logic [LEN_W-1:0]   rem;
        logic [OWNER_W-1:0] owner;
    } commit_t;

    typedef struct packed {
        logic             en;
        logic [LEN_W-1:0] size;
    } init_t;

endpackage

// ===== hdl/first_fit_segment_allocator.sv =====
// Top level of the first-fit segment allocator: control, cell row and result register.
//
//  channel  signals                          direction  carries
//  in       in_valid / in_ready / in_data    to block   req_t: owner_id, request_units
//  out      out_valid / out_ready / out_data from block resp_t: grant, position, address, free
//  cfg      cfg_write_en / cfg_write_data    to block   memory_size, reinitializes the table
//
// A request is handled in two steps: the search wave walks the cell row one
// entry per cycle, then the table update (and split shift) lands in one commit.
// A zero request is answered without a search. Reset gives one free segment of 256 units.
// One request is in flight at a time; in_ready is low until the result is transferred.
module first_fit_segment_allocator
    import ffsa_pkg::*;
#(
    parameter int MAX_SEGMENTS = MAX_SEGMENTS_DEF
)
(
    input  logic             clk,
    input  logic             rst_n,
    input  logic             in_valid,
    output logic             in_ready,
    input  req_t             in_data,
    output logic             out_valid,
    input  logic             out_ready,
    output resp_t            out_data,
    input  logic             cfg_write_en,
    input  logic [LEN_W-1:0] cfg_write_data
);

    localparam int IDX_W = $clog2(MAX_SEGMENTS);
    localparam int CNT_W = $clog2(MAX_SEGMENTS + 1);

    typedef enum logic [2:0] {
        ST_IDLE = 3'b001,
        ST_SCAN = 3'b010,
        ST_RESP = 3'b100
    } state_t;

    state_t             state_reg, state_next;
    resp_t              resp_reg, resp_next;
    logic [LEN_W-1:0]   need_reg, need_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    logic [CNT_W-1:0]   count_reg, count_next;
    logic [LEN_W-1:0]   free_reg, free_next;

    wave_t              wave   [MAX_SEGMENTS+1];
    logic [IDX_W-1:0]   widx   [MAX_SEGMENTS+1];
    logic [LEN_W-1:0]   c_len  [MAX_SEGMENTS];
    logic               c_used [MAX_SEGMENTS];
    logic [OWNER_W-1:0] c_own  [MAX_SEGMENTS];

    init_t              init;
    commit_t            commit;
    logic [IDX_W-1:0]   commit_idx;
    wave_t              last;
    logic               split;
    logic               full;
    logic               launch;

    assign init.en   = cfg_write_en;
    assign init.size = cfg_write_data;

    assign last  = wave[MAX_SEGMENTS];
    assign split = last.len != need_reg;
    assign full  = count_reg >= CNT_W'(MAX_SEGMENTS);

    assign in_ready  = (state_reg == ST_IDLE);
    assign out_valid = (state_reg == ST_RESP);
    assign out_data  = resp_reg;
    assign launch    = in_valid && in_ready && (in_data.request_units != '0);

    assign wave[0].act   = launch;
    assign wave[0].found = 1'b0;
    assign wave[0].addr  = '0;
    assign wave[0].len   = '0;
    assign widx[0]       = '0;

    assign commit.en    = (state_reg == ST_SCAN) && last.act && last.found
                          && !(split && full);
    assign commit.split = split;
    assign commit.need  = need_reg;
    assign commit.rem   = last.len - need_reg;
    assign commit.owner = owner_reg;
    assign commit_idx   = widx[MAX_SEGMENTS];

    for (genvar g = 0; g < MAX_SEGMENTS; g++)
    begin : g_cell
        logic [LEN_W-1:0]   p_len;
        logic               p_used;
        logic [OWNER_W-1:0] p_own;
        if (g == 0)
        begin : g_first
            assign p_len  = '0;
            assign p_used = 1'b0;
            assign p_own  = '0;
        end
        else
        begin : g_rest
            assign p_len  = c_len[g-1];
            assign p_used = c_used[g-1];
            assign p_own  = c_own[g-1];
        end
        // the first cell sees the wave in the transfer cycle, before need_reg loads
        ffsa_cell #(
            .INDEX (g),
            .IDX_W (IDX_W)
        ) u_cell (
            .clk        (clk),
            .rst_n      (rst_n),
            .init       (init),
            .wave_in    (wave[g]),
            .idx_in     (widx[g]),
            .need       (need_next),
            .wave_out   (wave[g+1]),
            .idx_out    (widx[g+1]),
            .commit     (commit),
            .commit_idx (commit_idx),
            .prev_len   (p_len),
            .prev_used  (p_used),
            .prev_owner (p_own),
            .len        (c_len[g]),
            .used       (c_used[g]),
            .owner      (c_own[g])
        );
    end

    always_comb
    begin
        state_next = state_reg;
        resp_next  = resp_reg;
        need_next  = need_reg;
        owner_next = owner_reg;
        count_next = count_reg;
        free_next  = free_reg;
        unique case (state_reg)
            ST_IDLE:
            begin
                if (in_valid)
                begin
                    need_next  = {in_data.request_units, 1'b0};
                    owner_next = in_data.owner_id;
                    if (in_data.request_units == '0)
                    begin
                        resp_next  = '{granted: 1'b0, segment_position: '0,
                                      start_address: '0, free_remaining: free_reg};
                        state_next = ST_RESP;
                    end
                    else
                    begin
                        state_next = ST_SCAN;
                    end
                end
            end
            ST_SCAN:
            begin
                if (last.act)
                begin
                    state_next = ST_RESP;
                    if (commit.en)
                    begin
                        free_next = free_reg - need_reg;
                        if (split)
                        begin
                            count_next = count_reg + 1'b1;
                        end
                        resp_next.granted          = 1'b1;
                        resp_next.segment_position = POS_W'({1'b0, commit_idx} + 1'b1);
                        resp_next.start_address    = last.addr;
                        resp_next.free_remaining   = free_reg - need_reg;
                    end
                    else
                    begin
                        resp_next = '{granted: 1'b0, segment_position: '0,
                                      start_address: '0, free_remaining: free_reg};
                    end
                end
            end
            ST_RESP:
            begin
                if (out_ready)
                begin
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
        if (cfg_write_en)
        begin
            count_next = CNT_W'(1);
            free_next  = cfg_write_data;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= ST_IDLE;
            count_reg <= CNT_W'(1);
            free_reg  <= RESET_SIZE;
        end
        else
        begin
            state_reg <= state_next;
            count_reg <= count_next;
            free_reg  <= free_next;
        end
    end

    always_ff @(posedge clk)
    begin
        resp_reg  <= resp_next;
        need_reg  <= need_next;
        owner_reg <= owner_next;
    end

endmodule

// ===== hdl/ffsa_cell.sv =====
// One table entry of the allocator with its stage of the search wave.
module ffsa_cell
    import ffsa_pkg::*;
#(
    parameter int INDEX = 0,
    parameter int IDX_W = 6
)
(
    input  logic               clk,
    input  logic               rst_n,
    input  init_t              init,
    input  wave_t              wave_in,
    input  logic [IDX_W-1:0]   idx_in,
    input  logic [LEN_W-1:0]   need,
    output wave_t              wave_out,
    output logic [IDX_W-1:0]   idx_out,
    input  commit_t            commit,
    input  logic [IDX_W-1:0]   commit_idx,
    input  logic [LEN_W-1:0]   prev_len,
    input  logic               prev_used,
    input  logic [OWNER_W-1:0] prev_owner,
    output logic [LEN_W-1:0]   len,
    output logic               used,
    output logic [OWNER_W-1:0] owner
);

    logic [LEN_W-1:0]   len_reg, len_next;
    logic               used_reg, used_next;
    logic [OWNER_W-1:0] owner_reg, owner_next;
    wave_t              wave_reg, wave_next;
    logic [IDX_W-1:0]   idx_reg, idx_next;
    logic               fit;
    logic [IDX_W:0]     here;
    logic [IDX_W:0]     after_hit;

    localparam logic [LEN_W-1:0] INIT_LEN = (INDEX == 0) ? RESET_SIZE : '0;

    assign fit       = !used_reg && (need <= len_reg);
    assign here      = (IDX_W+1)'(INDEX);
    assign after_hit = {1'b0, commit_idx} + 1'b1;

    always_comb
    begin
        wave_next = wave_in;
        idx_next  = idx_in;
        if (wave_in.act && !wave_in.found)
        begin
            if (fit)
            begin
                wave_next.found = 1'b1;
                wave_next.len   = len_reg;
                idx_next        = IDX_W'(INDEX);
            end
            else
            begin
                wave_next.addr = wave_in.addr + len_reg;
            end
        end
    end

    always_comb
    begin
        len_next   = len_reg;
        used_next  = used_reg;
        owner_next = owner_reg;
        if (init.en)
        begin
            len_next   = (INDEX == 0) ? init.size : '0;
            used_next  = 1'b0;
            owner_next = '0;
        end
        else if (commit.en)
        begin
            if (here == {1'b0, commit_idx})
            begin
                len_next   = commit.need;
                used_next  = 1'b1;
                owner_next = commit.owner;
            end
            else if (commit.split && here == after_hit)
            begin
                len_next   = commit.rem;
                used_next  = 1'b0;
                owner_next = '0;
            end
            else if (commit.split && here > after_hit)
            begin
                // shift back by one entry
                len_next   = prev_len;
                used_next  = prev_used;
                owner_next = prev_owner;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            len_reg   <= INIT_LEN;
            used_reg  <= 1'b0;
            owner_reg <= '0;
            wave_reg  <= '0;
            idx_reg   <= '0;
        end
        else
        begin
            len_reg   <= len_next;
            used_reg  <= used_next;
            owner_reg <= owner_next;
            wave_reg  <= wave_next;
            idx_reg   <= idx_next;
        end
    end

    assign wave_out = wave_reg;
    assign idx_out  = idx_reg;
    assign len      = len_reg;
    assign used     = used_reg;
    assign owner    = owner_reg;

endmodule
